@@ design/binary_to_decimal_ascii_defines.svh @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define B2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define B2DA_IMPLIES(lbl, ante, cons, msg) \
  `B2DA_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define B2DA_IMPLIES_NEXT(lbl, ante, cons, msg) \
  `B2DA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ design/b2da_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg
// widths, constants and stage types of the decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_W      = 16;
  localparam int ASCII_W      = 6;
  localparam int NUM_DIGITS   = 5;
  localparam int DIGIT_W      = 4;
  localparam int IDX_W        = 3;
  // remainder times ten stays below 100000
  localparam int REST_W       = 17;
  localparam int PLACE_WEIGHT = 10000;
  localparam int RADIX        = 10;

  localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic [REST_W-1:0]                    rest;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;  // newest digit at index 0
  } cell_data_t;

  typedef struct packed {
    logic       vld;
    cell_data_t data;
  } stage_t;

  function automatic logic [REST_W-1:0] place_mult(input int k);
    return REST_W'(k * PLACE_WEIGHT);
  endfunction

endpackage
`default_nettype wire

@@ design/b2da_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da channel interfaces
// valid/ready channels for the binary value and the ascii characters
// ----------------------------------------------------------------------------
interface b2da_in_if import b2da_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if import b2da_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ASCII_W-1:0] ascii_char;
  logic               last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface
`default_nettype wire

@@ design/b2da_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_cell
// one decimal place: peels the leading digit and scales the remainder by ten
// ----------------------------------------------------------------------------
module b2da_cell import b2da_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  stage_t up,
  output logic   up_ready,
  output stage_t dn,
  input  logic   dn_ready
);

  logic              vld_r;
  cell_data_t        data_r;
  cell_data_t        data_nxt;
  logic [DIGIT_W-1:0] digit;
  logic [REST_W-1:0]  sub;
  logic [REST_W-1:0]  rem;

  // independent compares against the nine multiples of the place weight
  always_comb begin
    digit = '0;
    sub   = '0;
    for (int k = 1; k < RADIX; k++) begin
      if (up.data.rest >= place_mult(k)) begin
        digit = DIGIT_W'(k);
        sub   = place_mult(k);
      end
    end
    rem = up.data.rest - sub;
    data_nxt.rest   = (rem << 3) + (rem << 1);
    data_nxt.digits = {up.data.digits[NUM_DIGITS-2:0], digit};
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn.vld  = vld_r;
  assign dn.data = data_r;

endmodule
`default_nettype wire

@@ design/b2da_serializer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_serializer
// emits the buffered digits as ascii, skipping leading zeros
// ----------------------------------------------------------------------------
module b2da_serializer import b2da_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  stage_t             up,
  output logic               up_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ASCII_W-1:0] out_ascii,
  output logic               out_last
);

  logic                               busy_r;
  logic [IDX_W-1:0]                   idx_r;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_r;
  logic [IDX_W-1:0]                   first;

  // most significant nonzero digit, units place when all are zero
  always_comb begin
    first = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (up.data.digits[i] != '0) begin
        first = IDX_W'(i);
      end
    end
  end

  assign up_ready = !busy_r || (out_ready && idx_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (up_ready) begin
      busy_r <= up.vld;
      if (up.vld) begin
        idx_r <= first;
      end
    end else if (out_ready) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.vld) begin
      digits_r <= up.data.digits;
    end
  end

  assign out_valid = busy_r;
  assign out_ascii = ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, digits_r[idx_r]};
  assign out_last  = (idx_r == '0);

endmodule
`default_nettype wire

@@ design/binary_to_decimal_ascii.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// unsigned 16-bit value to decimal ascii text, most significant digit first
//
//   channel   dir  payload                      transaction
//   in_chan   in   value[15:0]                  one value to convert
//   out_chan  out  ascii_char[5:0], last_char   one character, last flags end
//
// - five digit cells in a row, one per decimal place; a value moves one cell
//   per cycle while nothing downstream stalls, and reaches the serializer after the last cell
// - the serializer sends one character per cycle while out_chan is ready: a value
//   gives 1 to 5 characters (its number of significant digits)
// - while a run is being sent the cells keep taking and converting values
// - synchronous active-low reset empties the cells and the serializer
// - out_chan stall freezes the character on the port and backs up the row
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import b2da_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  b2da_in_if.sink     in_chan,
  b2da_out_if.source  out_chan
);

  // link[k] feeds cell k, link[NUM_DIGITS] feeds the serializer
  stage_t link [NUM_DIGITS+1];
  logic   rdy  [NUM_DIGITS+1];

  // remainder starts as the value itself, no digits yet
  assign link[0].vld         = in_chan.valid;
  assign link[0].data.rest   = {{(REST_W-VALUE_W){1'b0}}, in_chan.value};
  assign link[0].data.digits = '0;
  assign in_chan.ready       = rdy[0];

  // each cell divides by the top place weight, then shifts the remainder up
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    b2da_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up       (link[k]),
      .up_ready (rdy[k]),
      .dn       (link[k+1]),
      .dn_ready (rdy[k+1])
    );
  end

  // output stage, also the skid point between the row and the consumer
  b2da_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up        (link[NUM_DIGITS]),
    .up_ready  (rdy[NUM_DIGITS]),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_ascii (out_chan.ascii_char),
    .out_last  (out_chan.last_char)
  );

endmodule
`default_nettype wire

@@ design/b2da_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker import b2da_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ASCII_W-1:0] out_ascii,
  input logic               out_last
);

  // a stalled character holds
  `B2DA_IMPLIES_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ascii) && $stable(out_last), "stalled character changed")

  // only decimal digit characters leave
  `B2DA_IMPLIES(a_digit_range, out_valid, out_ascii >= 6'd48 && out_ascii <= 6'd57, "character outside 0 to 9")

  // a run keeps going without gaps until its last character
  `B2DA_IMPLIES_NEXT(a_run_gapless, out_valid && out_ready && !out_last, out_valid, "gap inside a run")

  // with nothing to send, the block must take a value
  `B2DA_IMPLIES(a_idle_ready, !out_valid, in_ready, "idle output but input stalled")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_ascii (out_chan.ascii_char),
  .out_last  (out_chan.last_char)
);
`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for binary_to_decimal_ascii
// drives 16-bit values into the converter and checks every ascii character
// that comes back against a digit-by-digit prediction, under varying idle,
// stall and back-pressure patterns
// ----------------------------------------------------------------------------
module testbench import b2da_pkg::*;;

  // cycles with no transaction on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last character, well beyond the latency of the row
  localparam int END_SETTLE     = 20;
  // long receiver hold-off, enough to back the whole row up to the input
  localparam int HOLD_OFF       = 200;
  localparam int PHASE_ITEMS    = 105;
  localparam int HOLD_ITEMS     = 40;

  // one expected character on the result channel
  typedef struct packed {
    logic [ASCII_W-1:0] ascii_char;
    logic               last_char;
  } ascii_item_t;

  // predicts the character run of each value and checks results in order
  class decimal_text_scoreboard;
    ascii_item_t expected_chars[$];
    int unsigned mismatches;

    // split the value into decimal digits, most significant first, with no
    // leading zeros; zero still yields one digit
    function void note_value(input logic [VALUE_W-1:0] value);
      int unsigned        rest;
      logic [DIGIT_W-1:0] digits[$];
      ascii_item_t        item;
      rest = value;
      do begin
        digits.push_front(DIGIT_W'(rest % RADIX));
        rest = rest / RADIX;
      end while (rest != 0);
      foreach (digits[i]) begin
        item.ascii_char = ASCII_ZERO + ASCII_W'(digits[i]);
        item.last_char  = (i == digits.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_char(input logic [ASCII_W-1:0] ascii_char, input logic last_char);
      ascii_item_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual ascii_char=%0d last_char=%0b",
                 $time, ascii_char, last_char);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (ascii_char !== want.ascii_char) begin
        $display("%0t: ascii_char mismatch, expected %0d, actual %0d",
                 $time, want.ascii_char, ascii_char);
        mismatches++;
      end
      if (last_char !== want.last_char) begin
        $display("%0t: last_char mismatch, expected %0b, actual %0b",
                 $time, want.last_char, last_char);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  b2da_in_if  in_chan();
  b2da_out_if out_chan();

  binary_to_decimal_ascii u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  decimal_text_scoreboard text_sb = new();

  // idling controls, set by the main sequence and read by the drivers
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned hold_cycles;
  int unsigned quiet_cycles;

  // edges that cover every digit count, the decade boundaries, inner zeros
  // and both bit patterns of the value field
  logic [VALUE_W-1:0] corner_values[$] = '{
    16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
    16'd9999, 16'd10000, 16'd10001, 16'd65535, 16'd65534, 16'd60000,
    16'h8000, 16'h5555, 16'haaaa, 16'd12345, 16'd255, 16'd256, 16'd40302
  };

  // clock: period of 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // monitor: both channels sampled at the edge that accepts the transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        text_sb.note_value(in_chan.value);
      end
      if (out_chan.valid && out_chan.ready) begin
        text_sb.check_char(out_chan.ascii_char, out_chan.last_char);
      end
    end
  end

  // watchdog: too long with no transaction anywhere means the block is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // mostly values of a chosen digit count, some fully random bit patterns
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return VALUE_W'($urandom_range(9));
      1:       return VALUE_W'($urandom_range(99, 10));
      2:       return VALUE_W'($urandom_range(999, 100));
      3:       return VALUE_W'($urandom_range(9999, 1000));
      4:       return VALUE_W'($urandom_range(65535, 10000));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // offer one value, with random idle cycles ahead of it, until accepted;
  // valid stays high afterwards so back-to-back transactions need no gap
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= value;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // sender goes quiet until every predicted character has come back
  task automatic wait_for_text_drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (text_sb.pending() != 0);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.value = '0;
    rst_n         = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_cycles   = 0;
    quiet_cycles  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners, back to back
    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
    end
    wait_for_text_drain();

    // random phases: free flow, idle sender, stalling receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 49; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 49; end
        default: begin in_idle_pct = 25; out_stall_pct = 25; end
      endcase
      repeat (PHASE_ITEMS) send_value(pick_value());
      wait_for_text_drain();
    end

    // receiver holds off while values keep coming, so the row fills and the
    // input channel has to stall
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_cycles   = HOLD_OFF;
    repeat (HOLD_ITEMS) send_value(pick_value());
    wait_for_text_drain();

    // anything arriving now would be an extra character
    repeat (END_SETTLE) @(posedge clk);
    if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
